@@ rtl/core/arpc_pkg.sv @@
// Shared types, field widths and codes of the ARP cache and responder.
package arpc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam int unsigned IP_W   = 32;
  localparam int unsigned MAC_W  = 48;
  localparam int unsigned OPER_W = 16;
  localparam int unsigned ACT_W  = 2;

  // Sum of four IP bytes fits in 10 bits (max 1020).
  localparam int unsigned SUM_W       = 10;
  localparam int unsigned RECIP_SHIFT = 20;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  localparam logic [ACT_W-1:0] ACT_PACKET = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LEARN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

  localparam logic [OPER_W-1:0] OPER_REQUEST = 16'd1;
  localparam logic [OPER_W-1:0] OPER_REPLY   = 16'd2;

  // Register select, taken from paddr bit 3 (registers sit 8 bytes apart).
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [OPER_W-1:0] oper;
    logic [MAC_W-1:0]  peer_mac;
    logic [IP_W-1:0]   peer_ip;
    logic [IP_W-1:0]   target_ip;
  } item_t;

  typedef struct packed {
    logic             reply_valid;
    logic [MAC_W-1:0] reply_dest_mac;
    logic [IP_W-1:0]  reply_dest_ip;
    logic             hit;
    logic [MAC_W-1:0] hit_mac;
    logic             reply_seen;
  } res_t;

  function automatic logic [SUM_W-1:0] byte_sum(input logic [IP_W-1:0] ip);
    byte_sum = SUM_W'(ip[7:0]) + SUM_W'(ip[15:8]) + SUM_W'(ip[23:16]) + SUM_W'(ip[31:24]);
  endfunction

endpackage

@@ rtl/core/arp_cache_and_responder_unit.sv @@
// ARP cache and responder top level: config registers, engine, cache memory, output register.
//
// Input channel (in_valid_i/in_ready_o) takes one item per beat: a received ARP
// packet, a peer to learn, or a lookup. Output channel (out_valid_o/out_ready_i)
// returns exactly one result beat per item, in order.
// Requests, unused codes and items with a zero peer IP finish without touching
// the cache. Learn and lookup items and received replies hash the IP to a home
// slot (quotient, remainder and home states) and then walk the cache memory one
// slot per cycle from home to the last slot; a hit stops the walk. A learn with
// no hit passes through a write state. The single read port of the cache memory
// sets the walk's pace; one item is in flight at a time.
// The output register holds a finished result while the engine takes the next
// item; if the receiver stalls with a result still held, the engine waits with
// its own result until the register frees.
// After reset the cache is cleared one entry a cycle, through all TABLE_ENTRIES entries,
// with in_ready_o low; APB writes to own_ip (0x0) and own_mac (0x8) are taken
// at any time. pready is always high.
module arp_cache_and_responder_unit #(
  parameter int unsigned TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [arpc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [arpc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [arpc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [arpc_pkg::ACT_W-1:0]       action_i,
  input  logic [arpc_pkg::OPER_W-1:0]      oper_i,
  input  logic [arpc_pkg::MAC_W-1:0]       peer_mac_i,
  input  logic [arpc_pkg::IP_W-1:0]        peer_ip_i,
  input  logic [arpc_pkg::IP_W-1:0]        target_ip_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             reply_valid_o,
  output logic [arpc_pkg::MAC_W-1:0]       reply_dest_mac_o,
  output logic [arpc_pkg::IP_W-1:0]        reply_dest_ip_o,
  output logic                             hit_o,
  output logic [arpc_pkg::MAC_W-1:0]       hit_mac_o,
  output logic                             reply_seen_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [arpc_pkg::IP_W-1:0]  own_ip_q;
  logic [arpc_pkg::MAC_W-1:0] own_mac_q;
  logic                       cfg_wr;

  arpc_pkg::item_t item;
  arpc_pkg::res_t  res;
  arpc_pkg::res_t  out_q;
  logic            out_valid_q;
  logic            res_valid;
  logic            res_ready;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [arpc_pkg::IP_W-1:0]  mem_wip;
  logic [arpc_pkg::MAC_W-1:0] mem_wmac;
  logic [AW-1:0]              mem_raddr;
  logic [arpc_pkg::IP_W-1:0]  mem_rip;
  logic [arpc_pkg::MAC_W-1:0] mem_rmac;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[3] == arpc_pkg::REG_OWN_MAC) ?
                  arpc_pkg::APB_DATA_W'(own_mac_q) : arpc_pkg::APB_DATA_W'(own_ip_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q  <= '0;
      own_mac_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        arpc_pkg::REG_OWN_IP:  own_ip_q  <= pwdata[arpc_pkg::IP_W-1:0];
        arpc_pkg::REG_OWN_MAC: own_mac_q <= pwdata[arpc_pkg::MAC_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.action    = action_i;
  assign item.oper      = oper_i;
  assign item.peer_mac  = peer_mac_i;
  assign item.peer_ip   = peer_ip_i;
  assign item.target_ip = target_ip_i;

  arpc_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .item_i      (item),
    .own_ip_i    (own_ip_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wip_o   (mem_wip),
    .mem_wmac_o  (mem_wmac),
    .mem_raddr_o (mem_raddr),
    .mem_rip_i   (mem_rip),
    .mem_rmac_i  (mem_rmac)
  );

  arpc_mem #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wip_i   (mem_wip),
    .wmac_i  (mem_wmac),
    .raddr_i (mem_raddr),
    .rip_o   (mem_rip),
    .rmac_o  (mem_rmac)
  );

  // Output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reply_valid_o    = out_q.reply_valid;
  assign reply_dest_mac_o = out_q.reply_dest_mac;
  assign reply_dest_ip_o  = out_q.reply_dest_ip;
  assign hit_o            = out_q.hit;
  assign hit_mac_o        = out_q.hit_mac;
  assign reply_seen_o     = out_q.reply_seen;

`ifndef ASSERT_OFF
  a_one_item_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input beat taken while an item is in flight");

  a_miss_mac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_mac_o == '0)
    else $error("nonzero hit_mac on a miss");

  a_kinds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(reply_valid_o && (reply_seen_o || hit_o)) && !(hit_o && reply_seen_o))
    else $error("result mixes item kinds");
`endif

endmodule

@@ rtl/core/arpc_mem.sv @@
// Cache storage: IP and MAC arrays, one write port, one registered read port.
module arpc_mem #(
  parameter int unsigned TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned AW            = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [arpc_pkg::IP_W-1:0]  wip_i,
  input  logic [arpc_pkg::MAC_W-1:0] wmac_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [arpc_pkg::IP_W-1:0]  rip_o,
  output logic [arpc_pkg::MAC_W-1:0] rmac_o
);

  logic [arpc_pkg::IP_W-1:0]  ip_mem  [TABLE_ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] mac_mem [TABLE_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      ip_mem[waddr_i]  <= wip_i;
      mac_mem[waddr_i] <= wmac_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rip_o  <= ip_mem[raddr_i];
    rmac_o <= mac_mem[raddr_i];
  end

endmodule

@@ rtl/core/arpc_engine.sv @@
// Item sequencer: clear after reset, decode, home-slot hash, probe walk over the cache memory, insert.
module arpc_engine #(
  parameter int unsigned TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned AW            = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  arpc_pkg::item_t            item_i,
  input  logic [arpc_pkg::IP_W-1:0]  own_ip_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output arpc_pkg::res_t             res_o,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [arpc_pkg::IP_W-1:0]  mem_wip_o,
  output logic [arpc_pkg::MAC_W-1:0] mem_wmac_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [arpc_pkg::IP_W-1:0]  mem_rip_i,
  input  logic [arpc_pkg::MAC_W-1:0] mem_rmac_i
);

  localparam int unsigned SUM_W   = arpc_pkg::SUM_W;
  localparam int unsigned RECIP_W = arpc_pkg::RECIP_SHIFT + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned N_W     = SUM_W + 1;
  localparam int unsigned RECIP   = (1 << arpc_pkg::RECIP_SHIFT) / TABLE_ENTRIES;
  localparam logic [AW-1:0] LAST  = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_HASH_Q, ST_HASH_R, ST_HASH_H, ST_PROBE, ST_WRITE, ST_FINISH
  } state_e;

  typedef enum logic {OP_LEARN, OP_LOOKUP} op_e;

  state_e                     st_q, st_d;
  op_e                        op_q, op_d;
  logic [arpc_pkg::IP_W-1:0]  key_ip_q, key_ip_d;
  logic [arpc_pkg::MAC_W-1:0] key_mac_q, key_mac_d;
  logic [SUM_W-1:0]           sum_q, sum_d;
  logic [SUM_W-1:0]           quo_q, quo_d;
  logic [SUM_W-1:0]           rem_q, rem_d;
  logic [AW-1:0]              home_q, home_d;
  logic [AW-1:0]              iss_q, iss_d;
  logic                       iss_act_q, iss_act_d;
  logic [AW-1:0]              chk_q, chk_d;
  logic                       chk_vld_q, chk_vld_d;
  logic [AW-1:0]              emp_q, emp_d;
  logic                       emp_vld_q, emp_vld_d;
  logic [AW-1:0]              wr_q, wr_d;
  arpc_pkg::res_t             res_q, res_d;

  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  quo_n;
  logic [N_W-1:0]    rem_fix;
  logic              match;
  logic              slot_empty;

  // Byte sum times floor(2^K/N); the quotient may come out one low, fixed below.
  assign prod    = PROD_W'(sum_q) * PROD_W'(RECIP);
  assign quo_n   = SUM_W'(N_W'(quo_q) * N_W'(TABLE_ENTRIES));
  assign rem_fix = (N_W'(rem_q) >= N_W'(TABLE_ENTRIES)) ?
                   N_W'(rem_q) - N_W'(TABLE_ENTRIES) : N_W'(rem_q);

  assign match      = chk_vld_q && (mem_rip_i == key_ip_q);
  assign slot_empty = (mem_rip_i == '0);

  assign in_ready_o  = (st_q == ST_IDLE);
  assign res_valid_o = (st_q == ST_FINISH);
  assign res_o       = res_q;
  assign mem_raddr_o = iss_q;

  always_comb begin
    st_d        = st_q;
    op_d        = op_q;
    key_ip_d    = key_ip_q;
    key_mac_d   = key_mac_q;
    sum_d       = sum_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    home_d      = home_q;
    iss_d       = iss_q;
    iss_act_d   = iss_act_q;
    chk_d       = chk_q;
    chk_vld_d   = chk_vld_q;
    emp_d       = emp_q;
    emp_vld_d   = emp_vld_q;
    wr_d        = wr_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q;
    mem_wip_o   = key_ip_q;
    mem_wmac_o  = key_mac_q;

    unique case (st_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = iss_q;
        mem_wip_o   = '0;
        mem_wmac_o  = '0;
        if (iss_q == LAST) begin
          iss_d = '0;
          st_d  = ST_IDLE;
        end else begin
          iss_d = iss_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          key_ip_d  = item_i.peer_ip;
          key_mac_d = item_i.peer_mac;
          sum_d     = arpc_pkg::byte_sum(item_i.peer_ip);
          res_d     = '0;
          op_d      = OP_LOOKUP;
          st_d      = ST_FINISH;
          unique case (item_i.action)
            arpc_pkg::ACT_PACKET: begin
              if (item_i.oper == arpc_pkg::OPER_REQUEST) begin
                if (item_i.target_ip == own_ip_i) begin
                  res_d.reply_valid    = 1'b1;
                  res_d.reply_dest_mac = item_i.peer_mac;
                  res_d.reply_dest_ip  = item_i.peer_ip;
                end
              end else if (item_i.oper == arpc_pkg::OPER_REPLY) begin
                res_d.reply_seen = 1'b1;
                op_d             = OP_LEARN;
                if (item_i.peer_ip != '0) st_d = ST_HASH_Q;
              end
            end
            arpc_pkg::ACT_LEARN: begin
              op_d = OP_LEARN;
              if (item_i.peer_ip != '0) st_d = ST_HASH_Q;
            end
            arpc_pkg::ACT_LOOKUP: begin
              op_d = OP_LOOKUP;
              if (item_i.peer_ip != '0) st_d = ST_HASH_Q;
            end
            default: ;
          endcase
        end
      end
      ST_HASH_Q: begin
        quo_d = prod[arpc_pkg::RECIP_SHIFT +: SUM_W];
        st_d  = ST_HASH_R;
      end
      ST_HASH_R: begin
        rem_d = sum_q - quo_n;
        st_d  = ST_HASH_H;
      end
      ST_HASH_H: begin
        home_d    = AW'(rem_fix);
        iss_d     = AW'(rem_fix);
        iss_act_d = 1'b1;
        chk_vld_d = 1'b0;
        emp_vld_d = 1'b0;
        st_d      = ST_PROBE;
      end
      ST_PROBE: begin
        // Reads issue one slot a cycle; a slot's data returns in the cycle after its read, with it in chk_q.
        chk_vld_d = iss_act_q;
        chk_d     = iss_q;
        if (iss_act_q) begin
          if (iss_q == LAST) iss_act_d = 1'b0;
          else               iss_d     = iss_q + AW'(1);
        end
        if (match) begin
          if (op_q == OP_LOOKUP) begin
            res_d.hit     = 1'b1;
            res_d.hit_mac = mem_rmac_i;
          end
          st_d = ST_FINISH;
        end else if (chk_vld_q) begin
          if (slot_empty && !emp_vld_q) begin
            emp_vld_d = 1'b1;
            emp_d     = chk_q;
          end
          if (chk_q == LAST) begin
            if (op_q == OP_LEARN) begin
              // first empty slot from home on, else overwrite home
              if (emp_vld_q)       wr_d = emp_q;
              else if (slot_empty) wr_d = chk_q;
              else                 wr_d = home_q;
              st_d = ST_WRITE;
            end else begin
              st_d = ST_FINISH;
            end
          end
        end
      end
      ST_WRITE: begin
        mem_we_o = 1'b1;
        st_d     = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_ready_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLEAR;
      op_q      <= OP_LOOKUP;
      key_ip_q  <= '0;
      key_mac_q <= '0;
      sum_q     <= '0;
      quo_q     <= '0;
      rem_q     <= '0;
      home_q    <= '0;
      iss_q     <= '0;
      iss_act_q <= 1'b0;
      chk_q     <= '0;
      chk_vld_q <= 1'b0;
      emp_q     <= '0;
      emp_vld_q <= 1'b0;
      wr_q      <= '0;
      res_q     <= '0;
    end else begin
      st_q      <= st_d;
      op_q      <= op_d;
      key_ip_q  <= key_ip_d;
      key_mac_q <= key_mac_d;
      sum_q     <= sum_d;
      quo_q     <= quo_d;
      rem_q     <= rem_d;
      home_q    <= home_d;
      iss_q     <= iss_d;
      iss_act_q <= iss_act_d;
      chk_q     <= chk_d;
      chk_vld_q <= chk_vld_d;
      emp_q     <= emp_d;
      emp_vld_q <= emp_vld_d;
      wr_q      <= wr_d;
      res_q     <= res_d;
    end
  end

endmodule
